// File: hw/rtl/stereo_phaser_defines.svh
// Assertion macros shared by the stereo phaser RTL.
`ifndef STEREO_PHASER_DEFINES_SVH
`define STEREO_PHASER_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define SP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define SP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sp_pkg.sv
// Shared types, constants and table functions for the stereo phaser.
package sp_pkg;

    localparam int MAX_STAGES      = 12;
    localparam int SAMPLE_BITS     = 24;
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int STAGE_IDX_BITS = $clog2(MAX_STAGES);
    localparam int QTR_BITS       = TABLE_ADDR_BITS - 2;
    localparam int QTR_SIZE       = 1 << QTR_BITS;
    localparam int QIDX_W         = QTR_BITS + 1;
    localparam int FRAC_BITS      = 32 - TABLE_ADDR_BITS;
    localparam int PH_UP          = 32 - PHASE_BITS;
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int SMP_SHIFT      = 28 - SAMPLE_BITS;
    localparam int SMP_SH_R       = (SMP_SHIFT > 0) ? SMP_SHIFT : 0;
    localparam int SMP_SH_L       = (SMP_SHIFT < 0) ? -SMP_SHIFT : 0;
    localparam int DIV_STEPS      = 15;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

    localparam longint PA1   = 64'sd1686629713;
    localparam longint PA3   = -64'sd693598669;
    localparam longint PA5   = 64'sd85569306;
    localparam longint PA7   = -64'sd5026995;
    localparam longint PA9   = 64'sd172272;
    localparam longint ONE30 = 64'sd1073741824;

    localparam logic signed [15:0] COEF_MIN   = -16'sd32119;
    localparam logic signed [15:0] COEF_MAX   = 16'sd32703;
    localparam logic signed [15:0] SKEW_DEAD  = 16'sd327;
    localparam logic signed [29:0] SKEW_SCALE = 30'sd9830;

    // configuration register indexes
    localparam logic [2:0] REG_PHASE_INC  = 3'd0;
    localparam logic [2:0] REG_BASE_CUT   = 3'd1;
    localparam logic [2:0] REG_MOD_RANGE  = 3'd2;
    localparam logic [2:0] REG_FB_GAIN    = 3'd3;
    localparam logic [2:0] REG_STAGES     = 3'd4;
    localparam logic [2:0] REG_WAVE_SKEW  = 3'd5;
    localparam logic [2:0] REG_R_OFFSET   = 3'd6;

    typedef struct packed {
        logic [31:0]        phase_increment;
        logic [23:0]        base_cutoff;
        logic [23:0]        mod_range;
        logic [14:0]        feedback_gain;
        logic [3:0]         stage_count;
        logic signed [15:0] wave_skew;
        logic [31:0]        right_phase_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_ACCEPT, OP_PH, OP_SIN_A, OP_SIN_B, OP_SKEW, OP_CUT, OP_CHK,
        OP_COS, OP_DIVI, OP_DIV, OP_DIVE, OP_FB, OP_STG, OP_ECH, OP_LOAD
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic                      ch;
        logic [STAGE_IDX_BITS-1:0] stage;
    } cmd_t;

    typedef struct packed {
        logic skew_on;
        logic cut_bypass;
    } sts_t;

    // quarter-wave sine polynomial, Q30, clamped to 0..1
    function automatic logic signed [31:0] qval(input int r);
        longint x;
        longint x2;
        longint p;
        x  = longint'(r) <<< (30 - QTR_BITS);
        x2 = (x * x) >>> 30;
        p  = PA9;
        p  = PA7 + ((p * x2) >>> 30);
        p  = PA5 + ((p * x2) >>> 30);
        p  = PA3 + ((p * x2) >>> 30);
        p  = PA1 + ((p * x2) >>> 30);
        p  = (p * x) >>> 30;
        if (p > ONE30) p = ONE30;
        if (p < 0) p = 0;
        return 32'(p);
    endfunction

    typedef logic signed [31:0] qtab_t [QTR_SIZE];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QTR_SIZE; i++) t[i] = qval(i);
        return t;
    endfunction

    localparam qtab_t              QTAB = build_qtab();
    localparam logic signed [31:0] QTOP = qval(QTR_SIZE);

    function automatic logic signed [31:0] rom_rd(input logic [TABLE_ADDR_BITS-1:0] addr);
        logic [1:0]          q;
        logic [QTR_BITS-1:0] r;
        logic [QIDX_W-1:0]   rr;
        logic signed [31:0]  p;
        q  = addr[TABLE_ADDR_BITS-1 -: 2];
        r  = addr[QTR_BITS-1:0];
        rr = q[0] ? (QIDX_W'(QTR_SIZE) - {1'b0, r}) : {1'b0, r};
        p  = rr[QTR_BITS] ? QTOP : QTAB[rr[QTR_BITS-1:0]];
        return q[1] ? -p : p;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -36'sh080000000) return -32'sh80000000;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] sample_in(input logic signed [SAMPLE_BITS-1:0] s);
        return 32'((longint'(s) <<< SMP_SH_R) >>> SMP_SH_L);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sample_out(input logic signed [31:0] y);
        longint v;
        longint hi;
        v  = (longint'(y) >>> SMP_SH_R) <<< SMP_SH_L;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [STAGE_IDX_BITS-1:0] last_stage(input logic [3:0] sc);
        int n;
        n = int'(sc);
        if (n < 2) n = 2;
        if (n > MAX_STAGES) n = MAX_STAGES;
        return STAGE_IDX_BITS'(n - 1);
    endfunction

endpackage

// File: hw/rtl/stereo_phaser.sv
// Stereo phaser top level: stream ports, configuration registers, checks.
//
// Input stream s_*: one stereo pair per request, left in the low half of
// s_tdata. Output stream m_*: one wet pair per input request, same packing.
// Configuration: cfg_we with cfg_index (register number) and cfg_wdata;
// write only while the block is idle. Index seven is ignored.
// One pair is processed at a time: both channels run in turn through the
// sine interpolator, a 15-step restoring divider for the allpass coefficient
// and the single allpass multiply-add, once per active stage. With skew on,
// the sine is looked up again at the skewed phase; the divider is skipped
// when the cutoff is zero or at or above Nyquist. s_tready returns once the
// result is loaded into the output register. A finished pair waits in the
// output register while m_tready is low; the next pair may be accepted and
// computed meanwhile, but is held back until the register is free. Reset
// clears the LFO phase, all stage and feedback state and the registers
// (stage count to four), and drops m_tvalid.
`include "stereo_phaser_defines.svh"

module stereo_phaser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sp_pkg::TDATA_W-1:0] s_tdata,   // left_sample, right_sample
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sp_pkg::TDATA_W-1:0] m_tdata,   // left_out, right_out
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [31:0]                cfg_wdata
);

    sp_pkg::cfg_t                      cfg_reg;
    sp_pkg::cmd_t                      cmd;
    sp_pkg::sts_t                      sts;
    logic [sp_pkg::STAGE_IDX_BITS-1:0] n_last;
    logic [sp_pkg::SAMPLE_BITS-1:0]    left_out;
    logic [sp_pkg::SAMPLE_BITS-1:0]    right_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg                    <= '0;
            cfg_reg.stage_count        <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sp_pkg::REG_PHASE_INC: cfg_reg.phase_increment    <= cfg_wdata;
                sp_pkg::REG_BASE_CUT:  cfg_reg.base_cutoff        <= cfg_wdata[23:0];
                sp_pkg::REG_MOD_RANGE: cfg_reg.mod_range          <= cfg_wdata[23:0];
                sp_pkg::REG_FB_GAIN:   cfg_reg.feedback_gain      <= cfg_wdata[14:0];
                sp_pkg::REG_STAGES:    cfg_reg.stage_count        <= cfg_wdata[3:0];
                sp_pkg::REG_WAVE_SKEW: cfg_reg.wave_skew          <= cfg_wdata[15:0];
                sp_pkg::REG_R_OFFSET:  cfg_reg.right_phase_offset <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign n_last = sp_pkg::last_stage(cfg_reg.stage_count);

    sp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .m_ready (m_tready),
        .n_last  (n_last),
        .sts     (sts),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .cmd     (cmd)
    );

    sp_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .sts       (sts),
        .left_out  (left_out),
        .right_out (right_out)
    );

    assign m_tdata = sp_pkg::TDATA_W'({right_out, left_out});

    `SP_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `SP_ASSERT_IMP(a_stage_in_range, cmd.op == sp_pkg::OP_STG, cmd.stage <= n_last, "stage overrun")
    `SP_ASSERT_NXT(a_load_sets_valid, cmd.op == sp_pkg::OP_LOAD, m_tvalid, "load lost")
    `SP_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, cmd.op != sp_pkg::OP_LOAD, "result overwritten")

endmodule

// File: hw/rtl/sp_ctrl.sv
// Sequencer for the stereo phaser: walks LFO, coefficient and allpass steps.
module sp_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              m_ready,
    input  logic [sp_pkg::STAGE_IDX_BITS-1:0] n_last,
    input  sp_pkg::sts_t                      sts,
    output logic                              s_ready,
    output logic                              m_valid,
    output sp_pkg::cmd_t                      cmd
);

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001, ST_PH   = 21'h000002, ST_LFA  = 21'h000004,
        ST_LFB  = 21'h000008, ST_SKW  = 21'h000010, ST_SKA  = 21'h000020,
        ST_SKB  = 21'h000040, ST_CUT  = 21'h000080, ST_CHK  = 21'h000100,
        ST_SNA  = 21'h000200, ST_SNB  = 21'h000400, ST_COS  = 21'h000800,
        ST_CSA  = 21'h001000, ST_CSB  = 21'h002000, ST_DIVI = 21'h004000,
        ST_DIV  = 21'h008000, ST_DIVE = 21'h010000, ST_FB   = 21'h020000,
        ST_STG  = 21'h040000, ST_ECH  = 21'h080000, ST_WAIT = 21'h100000
    } state_t;

    state_t                            state_reg, state_next;
    logic                              ch_reg, ch_next;
    logic [sp_pkg::STAGE_IDX_BITS-1:0] stage_reg, stage_next;
    logic [sp_pkg::DIV_CNT_BITS-1:0]   div_reg, div_next;
    logic                              m_valid_reg, m_valid_next;
    sp_pkg::op_t                       op;

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        stage_next   = stage_reg;
        div_next     = div_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op           = sp_pkg::OP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = sp_pkg::OP_ACCEPT;
                    ch_next    = 1'b0;
                    state_next = ST_PH;
                end
            end
            ST_PH: begin
                op         = sp_pkg::OP_PH;
                state_next = ST_LFA;
            end
            ST_LFA: begin
                op         = sp_pkg::OP_SIN_A;
                state_next = ST_LFB;
            end
            ST_LFB: begin
                op         = sp_pkg::OP_SIN_B;
                state_next = sts.skew_on ? ST_SKW : ST_CUT;
            end
            ST_SKW: begin
                op         = sp_pkg::OP_SKEW;
                state_next = ST_SKA;
            end
            ST_SKA: begin
                op         = sp_pkg::OP_SIN_A;
                state_next = ST_SKB;
            end
            ST_SKB: begin
                op         = sp_pkg::OP_SIN_B;
                state_next = ST_CUT;
            end
            ST_CUT: begin
                op         = sp_pkg::OP_CUT;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                op         = sp_pkg::OP_CHK;
                state_next = sts.cut_bypass ? ST_FB : ST_SNA;
            end
            ST_SNA: begin
                op         = sp_pkg::OP_SIN_A;
                state_next = ST_SNB;
            end
            ST_SNB: begin
                op         = sp_pkg::OP_SIN_B;
                state_next = ST_COS;
            end
            ST_COS: begin
                op         = sp_pkg::OP_COS;
                state_next = ST_CSA;
            end
            ST_CSA: begin
                op         = sp_pkg::OP_SIN_A;
                state_next = ST_CSB;
            end
            ST_CSB: begin
                op         = sp_pkg::OP_SIN_B;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                op         = sp_pkg::OP_DIVI;
                div_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                op       = sp_pkg::OP_DIV;
                div_next = div_reg + 1'b1;
                if (div_reg == sp_pkg::DIV_CNT_BITS'(sp_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_DIVE;
                end
            end
            ST_DIVE: begin
                op         = sp_pkg::OP_DIVE;
                state_next = ST_FB;
            end
            ST_FB: begin
                op         = sp_pkg::OP_FB;
                stage_next = '0;
                state_next = ST_STG;
            end
            ST_STG: begin
                op         = sp_pkg::OP_STG;
                stage_next = stage_reg + 1'b1;
                if (stage_reg == n_last) state_next = ST_ECH;
            end
            ST_ECH: begin
                op = sp_pkg::OP_ECH;
                if (!ch_reg) begin
                    ch_next    = 1'b1;
                    state_next = ST_PH;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // result register free or being drained this cycle
                if (!m_valid_reg || m_ready) begin
                    op           = sp_pkg::OP_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= 1'b0;
            stage_reg   <= '0;
            div_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            stage_reg   <= stage_next;
            div_reg     <= div_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign cmd.op    = op;
    assign cmd.ch    = ch_reg;
    assign cmd.stage = stage_reg;

endmodule

// File: hw/rtl/sp_dpath.sv
// Datapath: LFO phase, sine interpolation, coefficient divider, allpass stages.
module sp_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sp_pkg::cfg_t                   cfg,
    input  sp_pkg::cmd_t                   cmd,
    input  logic [sp_pkg::TDATA_W-1:0]     in_data,
    output sp_pkg::sts_t                   sts,
    output logic [sp_pkg::SAMPLE_BITS-1:0] left_out,
    output logic [sp_pkg::SAMPLE_BITS-1:0] right_out
);

    localparam int TAB = sp_pkg::TABLE_ADDR_BITS;
    localparam int FB  = sp_pkg::FRAC_BITS;
    localparam int SB  = sp_pkg::SAMPLE_BITS;

    logic [sp_pkg::PHASE_BITS-1:0] lfo_reg;
    logic signed [31:0]            x_in_reg [2];
    logic signed [31:0]            fb_reg [2];
    logic signed [31:0]            dly_reg [2][sp_pkg::MAX_STAGES];
    logic signed [31:0]            outs_reg [2][sp_pkg::MAX_STAGES];
    logic [31:0]                   ph_reg;
    logic [31:0]                   sin_arg_reg;
    logic signed [31:0]            s0_reg;
    logic signed [32:0]            diff_reg;
    logic [FB-1:0]                 frac_reg;
    logic signed [31:0]            sin_reg;
    logic signed [31:0]            sn_reg;
    logic [25:0]                   f_reg;
    logic [47:0]                   rem_reg;
    logic [47:0]                   dsh_reg;
    logic [14:0]                   q_reg;
    logic                          ovf_reg;
    logic                          neg_reg;
    logic signed [15:0]            coef_reg [2];
    logic signed [31:0]            x_reg;
    logic [SB-1:0]                 res_reg [2];
    logic [SB-1:0]                 left_out_reg;
    logic [SB-1:0]                 right_out_reg;

    logic [sp_pkg::PHASE_BITS-1:0] ph_sum;
    logic [TAB-1:0]                addr;
    logic signed [31:0]            s0;
    logic signed [31:0]            s1;
    logic signed [55:0]            ip;
    logic signed [29:0]            skew_k;
    logic signed [61:0]            skp;
    logic [30:0]                   u;
    logic [54:0]                   mp;
    logic [25:0]                   f;
    logic signed [32:0]            den_s;
    logic [31:0]                   den;
    logic [30:0]                   cs_mag;
    logic [47:0]                   dvd;
    logic [16:0]                   mag;
    logic signed [17:0]            cv;
    logic signed [46:0]            fbp;
    logic signed [31:0]            x_fb;
    logic signed [32:0]            sd;
    logic signed [48:0]            pr;
    logic signed [31:0]            y;

    always_comb begin
        ph_sum = cmd.ch ? (lfo_reg + cfg.right_phase_offset[31 -: sp_pkg::PHASE_BITS])
                        : lfo_reg;
        addr   = sin_arg_reg[31 -: TAB];
        s0     = sp_pkg::rom_rd(addr);
        s1     = sp_pkg::rom_rd(addr + TAB'(1));
        ip     = 56'(diff_reg) * 56'($signed({1'b0, frac_reg}));
        skew_k = 30'(cfg.wave_skew) * sp_pkg::SKEW_SCALE;
        skp    = 62'(skew_k) * 62'(sin_reg);
        u      = 31'((33'(sin_reg) + 33'sd1073741824) >>> 1);
        mp     = 55'(cfg.mod_range) * 55'(u);
        f      = 26'(cfg.base_cutoff) + 26'(mp >> 30);
        den_s  = 33'(sn_reg) + 33'sd1073741824;
        den    = (den_s < 33'sd1) ? 32'd1 : den_s[31:0];
        cs_mag = sin_reg[31] ? 31'(-33'(sin_reg)) : 31'(sin_reg);
        dvd    = (48'(cs_mag) << 15) + 48'(den >> 1);
        mag    = ovf_reg ? 17'd32768 : {2'b00, q_reg};
        cv     = neg_reg ? -$signed(18'(mag)) : $signed(18'(mag));
        if (cv > 18'(sp_pkg::COEF_MAX)) cv = 18'(sp_pkg::COEF_MAX);
        if (cv < 18'(sp_pkg::COEF_MIN)) cv = 18'(sp_pkg::COEF_MIN);
        fbp    = 47'(fb_reg[cmd.ch]) * 47'($signed({1'b0, cfg.feedback_gain}));
        x_fb   = sp_pkg::sat32(36'(x_in_reg[cmd.ch]) + 36'(fbp >>> 15));
        sd     = 33'(outs_reg[cmd.ch][cmd.stage]) - 33'(x_reg);
        pr     = 49'(coef_reg[cmd.ch]) * 49'(sd);
        y      = sp_pkg::sat32(36'(dly_reg[cmd.ch][cmd.stage]) + 36'(pr >>> 15));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfo_reg <= '0;
            for (int c = 0; c < 2; c++) begin
                fb_reg[c] <= '0;
                for (int i = 0; i < sp_pkg::MAX_STAGES; i++) begin
                    dly_reg[c][i]  <= '0;
                    outs_reg[c][i] <= '0;
                end
            end
        end else begin
            unique case (cmd.op)
                sp_pkg::OP_NOP: ;
                sp_pkg::OP_ACCEPT: begin
                    lfo_reg     <= lfo_reg + cfg.phase_increment[sp_pkg::PHASE_BITS-1:0];
                    x_in_reg[0] <= sp_pkg::sample_in(in_data[SB-1:0]);
                    x_in_reg[1] <= sp_pkg::sample_in(in_data[2*SB-1:SB]);
                end
                sp_pkg::OP_PH: begin
                    ph_reg      <= 32'(ph_sum) << sp_pkg::PH_UP;
                    sin_arg_reg <= 32'(ph_sum) << sp_pkg::PH_UP;
                end
                sp_pkg::OP_SIN_A: begin
                    s0_reg   <= s0;
                    diff_reg <= 33'(s1) - 33'(s0);
                    frac_reg <= sin_arg_reg[FB-1:0];
                end
                sp_pkg::OP_SIN_B: sin_reg <= s0_reg + 32'(ip >>> FB);
                sp_pkg::OP_SKEW:  sin_arg_reg <= ph_reg + skp[59:28];
                sp_pkg::OP_CUT:   f_reg <= f;
                sp_pkg::OP_CHK: begin
                    coef_reg[cmd.ch] <= (f_reg == '0) ? 16'sd0 : sp_pkg::COEF_MIN;
                    sin_arg_reg      <= {1'b0, f_reg[22:0], 8'h00};
                end
                sp_pkg::OP_COS: begin
                    sn_reg      <= sin_reg;
                    sin_arg_reg <= sin_arg_reg + 32'h4000_0000;
                end
                sp_pkg::OP_DIVI: begin
                    rem_reg <= dvd;
                    dsh_reg <= 48'(den) << 14;
                    ovf_reg <= dvd >= (48'(den) << 15);
                    neg_reg <= sin_reg[31];
                    q_reg   <= '0;
                end
                sp_pkg::OP_DIV: begin
                    // one quotient bit per cycle
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[13:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[13:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                end
                sp_pkg::OP_DIVE: coef_reg[cmd.ch] <= 16'(cv);
                sp_pkg::OP_FB:   x_reg <= x_fb;
                sp_pkg::OP_STG: begin
                    dly_reg[cmd.ch][cmd.stage]  <= x_reg;
                    outs_reg[cmd.ch][cmd.stage] <= y;
                    x_reg                       <= y;
                end
                sp_pkg::OP_ECH: begin
                    fb_reg[cmd.ch]  <= x_reg;
                    res_reg[cmd.ch] <= sp_pkg::sample_out(x_reg);
                end
                sp_pkg::OP_LOAD: begin
                    left_out_reg  <= res_reg[0];
                    right_out_reg <= res_reg[1];
                end
            endcase
        end
    end

    assign sts.skew_on    = (cfg.wave_skew > sp_pkg::SKEW_DEAD) ||
                            (cfg.wave_skew < -sp_pkg::SKEW_DEAD);
    assign sts.cut_bypass = (f_reg == '0) || (f_reg[25:23] != 3'b000);
    assign left_out       = left_out_reg;
    assign right_out      = right_out_reg;

endmodule
